// ===== design/ssgs_pkg.sv =====
// ----------------------------------------------------------------------------
// ssgs_pkg
// Shared constants, register map, types and coefficient selection for the
// separable Gaussian smoothing block.
// ----------------------------------------------------------------------------
package ssgs_pkg;

    localparam int DEF_MAX_TAPS   = 8;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    localparam int COEF_BITS  = 16;
    localparam int ROW_BITS   = 12;
    localparam int COL_BITS   = 10;
    localparam int MAX_HEIGHT = 4096;
    localparam int APB_AW     = 6;
    localparam int APB_DW     = 64;

    localparam logic [2:0] REG_TAPS    = 3'd0;
    localparam logic [2:0] REG_WIDTH   = 3'd1;
    localparam logic [2:0] REG_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_COEF_LO = 3'd3;
    localparam logic [2:0] REG_COEF_HI = 3'd4;

    typedef struct packed {
        logic [3:0]  tap_count;
        logic [10:0] line_width;
        logic [12:0] frame_height;
        logic [63:0] coeffs_low;
        logic [63:0] coeffs_high;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic acc_clr;
        logic issue;
        logic src_line;
        logic hv_load;
        logic res_load;
        logic mem_wr;
    } t_cmd;

    typedef struct packed {
        logic h_ok;
        logic v_ok;
        logic out_free;
    } t_stat;

    function automatic logic [COEF_BITS-1:0] coeff_sel(input logic [63:0] lo,
                                                       input logic [63:0] hi,
                                                       input logic [3:0]  tap);
        logic [COEF_BITS-1:0] c;
        c = '0;
        if (tap < 4'd4) begin
            c = lo[{tap[1:0], 4'b0000} +: COEF_BITS];
        end else if (tap < 4'd8) begin
            c = hi[{tap[1:0], 4'b0000} +: COEF_BITS];
        end
        return c;
    endfunction

endpackage

// ===== design/ssgs_px_if.sv =====
// ----------------------------------------------------------------------------
// ssgs_px_if
// Pixel input channel: valid/ready with pixel word and frame start flag.
// ----------------------------------------------------------------------------
interface ssgs_px_if #(
    parameter int PIXEL_BITS = ssgs_pkg::DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;

    modport source (output valid, pixel, frame_start, input ready);
    modport sink   (input valid, pixel, frame_start, output ready);
endinterface

// ===== design/ssgs_res_if.sv =====
// ----------------------------------------------------------------------------
// ssgs_res_if
// Result channel: valid/ready with smoothed pixel, position and last flag.
// ----------------------------------------------------------------------------
interface ssgs_res_if #(
    parameter int PIXEL_BITS = ssgs_pkg::DEF_PIXEL_BITS
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] smoothed;
    logic [11:0]           out_row;
    logic [9:0]            out_col;
    logic                  last_of_frame;

    modport source (output valid, smoothed, out_row, out_col, last_of_frame,
                    input ready);
    modport sink   (input valid, smoothed, out_row, out_col, last_of_frame,
                    output ready);
endinterface

// ===== design/ssgs_regs.sv =====
// ----------------------------------------------------------------------------
// ssgs_regs
// APB configuration registers: tap count, frame size and coefficients.
// ----------------------------------------------------------------------------
module ssgs_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssgs_pkg::APB_AW-1:0]   paddr,
    input  logic [ssgs_pkg::APB_DW-1:0]   pwdata,
    output logic [ssgs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output ssgs_pkg::t_cfg                o_cfg
);
    import ssgs_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tap_count    <= 4'd1;
            r_cfg.line_width   <= 11'd640;
            r_cfg.frame_height <= 13'd480;
            r_cfg.coeffs_low   <= 64'd32768;
            r_cfg.coeffs_high  <= 64'd0;
        end else if (wr) begin
            unique case (idx)
                REG_TAPS:    r_cfg.tap_count    <= pwdata[3:0];
                REG_WIDTH:   r_cfg.line_width   <= pwdata[10:0];
                REG_HEIGHT:  r_cfg.frame_height <= pwdata[12:0];
                REG_COEF_LO: r_cfg.coeffs_low   <= pwdata;
                REG_COEF_HI: r_cfg.coeffs_high  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TAPS:    prdata = APB_DW'(r_cfg.tap_count);
            REG_WIDTH:   prdata = APB_DW'(r_cfg.line_width);
            REG_HEIGHT:  prdata = APB_DW'(r_cfg.frame_height);
            REG_COEF_LO: prdata = r_cfg.coeffs_low;
            REG_COEF_HI: prdata = r_cfg.coeffs_high;
            default:     prdata = '0;
        endcase
    end

endmodule

// ===== design/ssgs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssgs_ctrl
// Sequencer: steps the shared multiply-accumulate through horizontal and
// vertical tap terms of one pixel word at a time.
// ----------------------------------------------------------------------------
module ssgs_ctrl #(
    parameter int MAX_TAPS = ssgs_pkg::DEF_MAX_TAPS,
    localparam int JW      = $clog2(2 * MAX_TAPS - 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ssgs_pkg::t_stat i_stat,
    input  logic [JW-1:0]   i_last_idx,
    output ssgs_pkg::t_cmd  o_cmd,
    output logic [JW-1:0]   o_idx
);
    import ssgs_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_CHK  = 9'b000000010,
        S_HRUN = 9'b000000100,
        S_HDRN = 9'b000001000,
        S_HFIN = 9'b000010000,
        S_VRUN = 9'b000100000,
        S_VDRN = 9'b001000000,
        S_VFIN = 9'b010000000,
        S_WR   = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [JW-1:0] r_idx, n_idx;
    logic [1:0]    r_drn, n_drn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_drn   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_drn   <= n_drn;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_drn      = r_drn;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.h_ok) begin
                    o_cmd.acc_clr = 1'b1;
                    n_idx         = '0;
                    n_state       = S_HRUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_HRUN: begin
                o_cmd.issue = 1'b1;
                if (r_idx == i_last_idx) begin
                    n_drn   = '0;
                    n_state = S_HDRN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_HDRN: begin
                if (r_drn == 2'd2) n_state = S_HFIN;
                else               n_drn   = r_drn + 2'd1;
            end
            S_HFIN: begin
                o_cmd.hv_load = 1'b1;
                if (i_stat.v_ok) begin
                    o_cmd.acc_clr = 1'b1;
                    n_idx         = '0;
                    n_state       = S_VRUN;
                end else begin
                    n_state = S_WR;
                end
            end
            S_VRUN: begin
                o_cmd.issue    = 1'b1;
                o_cmd.src_line = 1'b1;
                if (r_idx == i_last_idx) begin
                    n_drn   = '0;
                    n_state = S_VDRN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_VDRN: begin
                if (r_drn == 2'd2) n_state = S_VFIN;
                else               n_drn   = r_drn + 2'd1;
            end
            S_VFIN: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.mem_wr   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_WR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_idx = r_idx;

endmodule

// ===== design/ssgs_dp.sv =====
// ----------------------------------------------------------------------------
// ssgs_dp
// Datapath: position counters, pixel window, line store, shared
// multiply-accumulate, rounding and the output register.
// ----------------------------------------------------------------------------
module ssgs_dp #(
    parameter int MAX_TAPS   = ssgs_pkg::DEF_MAX_TAPS,
    parameter int MAX_WIDTH  = ssgs_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = ssgs_pkg::DEF_PIXEL_BITS,
    localparam int JW        = $clog2(2 * MAX_TAPS - 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssgs_pkg::t_cfg        i_cfg,
    input  ssgs_pkg::t_cmd        i_cmd,
    input  logic [JW-1:0]         i_idx,
    output ssgs_pkg::t_stat       o_stat,
    output logic [JW-1:0]         o_last_idx,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic                  i_frame_start,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PIXEL_BITS-1:0] o_smoothed,
    output logic [11:0]           o_out_row,
    output logic [9:0]            o_out_col,
    output logic                  o_last_of_frame
);
    import ssgs_pkg::*;

    localparam int WIN   = 2 * MAX_TAPS - 1;
    localparam int SLOTS = 2 * MAX_TAPS - 2;
    localparam int KW    = $clog2(MAX_TAPS + 1);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(SLOTS);
    localparam int PW    = JW + 1;
    localparam int WW    = CW + 1;
    localparam int MID   = PIXEL_BITS + 4;
    localparam int PROD  = MID + COEF_BITS;
    localparam int ACCW  = PROD + JW;
    localparam int DEPTH = SLOTS << CW;

    // configuration, clamped
    logic [KW-1:0]       k, km1;
    logic [WW-1:0]       w;
    logic [12:0]         h;

    always_comb begin
        if (i_cfg.tap_count == 4'd0)                    k = KW'(1);
        else if (32'(i_cfg.tap_count) > 32'(MAX_TAPS)) k = KW'(MAX_TAPS);
        else                                            k = KW'(i_cfg.tap_count);
        if (i_cfg.line_width == 11'd0)                   w = WW'(1);
        else if (32'(i_cfg.line_width) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
        else                                             w = WW'(i_cfg.line_width);
        if (i_cfg.frame_height == 13'd0)                    h = 13'd1;
        else if (32'(i_cfg.frame_height) > 32'(MAX_HEIGHT)) h = 13'(MAX_HEIGHT);
        else                                                h = i_cfg.frame_height;
    end

    assign km1        = k - KW'(1);
    assign o_last_idx = JW'({km1, 1'b0});

    // position
    logic [ROW_BITS-1:0] r_row, r_pr, pr, n_row;
    logic [CW-1:0]       r_col, r_pc, pc, n_col;
    logic [SW-1:0]       r_slot, r_ps, ps, n_slot;

    always_comb begin
        pr     = i_frame_start ? '0 : r_row;
        pc     = i_frame_start ? '0 : r_col;
        ps     = i_frame_start ? '0 : r_slot;
        n_row  = pr;
        n_slot = ps;
        n_col  = pc + 1'b1;
        if (32'(pc) + 32'd1 >= 32'(w)) begin
            n_col = '0;
            if (32'(pr) + 32'd1 >= 32'(h)) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = pr + 1'b1;
                n_slot = (ps == SW'(SLOTS - 1)) ? '0 : ps + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_cmd.accept) begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pr <= pr;
            r_pc <= pc;
            r_ps <= ps;
        end
    end

    logic [CW-1:0]       cc;
    logic [ROW_BITS-1:0] centre;
    logic                last;

    assign cc     = r_pc - CW'(km1);
    assign centre = r_pr - ROW_BITS'(km1);
    assign last   = (32'(r_pr) == 32'(h) - 32'd1) && (32'(r_pc) == 32'(w) - 32'd1);

    assign o_stat.h_ok = (32'(r_pc) < 32'(w)) && (32'(r_pc) >= 32'(o_last_idx));
    assign o_stat.v_ok = (32'(r_pr) < 32'(h)) && (32'(r_pr) >= 32'(o_last_idx));

    // pixel window, newest at 0
    logic [PIXEL_BITS-1:0] r_win [WIN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN; i++) r_win[i] <= '0;
        end else if (i_cmd.accept) begin
            r_win[0] <= i_pixel;
            for (int i = 1; i < WIN; i++) r_win[i] <= r_win[i-1];
        end
    end

    // term operand selection
    logic [PW-1:0]        rs;
    logic [JW-1:0]        tap;
    logic [COEF_BITS-1:0] coef;
    logic [SW+CW-1:0]     rd_addr, wr_addr;

    always_comb begin
        if (PW'(r_ps) >= PW'(i_idx)) rs = PW'(r_ps) - PW'(i_idx);
        else                         rs = PW'(r_ps) + PW'(SLOTS) - PW'(i_idx);
        if (i_idx >= JW'(km1)) tap = i_idx - JW'(km1);
        else                   tap = JW'(km1) - i_idx;
    end

    assign coef    = coeff_sel(i_cfg.coeffs_low, i_cfg.coeffs_high, 4'(tap));
    assign rd_addr = {SW'(rs), cc};
    assign wr_addr = {r_ps, cc};

    // line store
    logic [MID-1:0] mem [DEPTH];
    logic [MID-1:0] r_mem_q, r_hv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) mem[wr_addr] <= r_hv;
        r_mem_q <= mem[rd_addr];
    end

    // multiply-accumulate pipeline
    logic                  r_s1_v, r_s2_v, r_s1_line, r_s1_zero;
    logic [COEF_BITS-1:0]  r_coef_q;
    logic [PIXEL_BITS-1:0] r_win_q;
    logic [MID-1:0]        opnd;
    logic [PROD-1:0]       r_prod;
    logic [ACCW-1:0]       r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_line <= i_cmd.src_line;
        r_s1_zero <= (i_idx == '0);
        r_coef_q  <= coef;
        r_win_q   <= r_win[i_idx];
        r_prod    <= PROD'(opnd) * PROD'(r_coef_q);
    end

    assign opnd = !r_s1_line ? MID'(r_win_q) : (r_s1_zero ? r_hv : r_mem_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr)  r_acc <= '0;
        else if (r_s2_v)    r_acc <= r_acc + ACCW'(r_prod);
    end

    // rounding and saturation
    logic [ACCW:0]            hrnd, vrnd;
    logic [ACCW-11:0]         hq;
    logic [ACCW-19:0]         vq;
    logic [MID-1:0]           hv;
    logic [PIXEL_BITS-1:0]    res;

    always_comb begin
        hrnd = {1'b0, r_acc} + (ACCW+1)'(1 << 10);
        vrnd = {1'b0, r_acc} + (ACCW+1)'(1 << 18);
        hq   = hrnd[ACCW:11];
        vq   = vrnd[ACCW:19];
        hv   = (|hq[ACCW-11:MID]) ? '1 : hq[MID-1:0];
        res  = (|vq[ACCW-19:PIXEL_BITS]) ? '1 : vq[PIXEL_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hv_load) r_hv <= hv;
    end

    // output register
    logic r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_ovalid <= 1'b0;
        else if (i_cmd.res_load) r_ovalid <= 1'b1;
        else if (i_ready)        r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            o_smoothed      <= res;
            o_out_row       <= centre;
            o_out_col       <= COL_BITS'(cc);
            o_last_of_frame <= last;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_stat.out_free = !r_ovalid || i_ready;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> (!r_ovalid || i_ready))
        else $error("result loaded over an untaken word");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (i_idx <= o_last_idx))
        else $error("tap term index past last tap");
    a_wr_h: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_wr |-> o_stat.h_ok)
        else $error("line write for a border column");
    a_no_mac_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> (!r_s1_v && !r_s2_v))
        else $error("word accepted with terms in flight");
`endif

endmodule

// ===== design/separable_symmetric_gaussian_smooth.sv =====
// ----------------------------------------------------------------------------
// separable_symmetric_gaussian_smooth
// Separable symmetric 2-D smoothing filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// i_px carries one pixel word per handshake, frame_start on the first pixel of
// a frame. o_res carries one filtered word for each pixel that lies K-1 rows
// and K-1 columns inside the frame, with its row, column and a last flag.
// Tap count, line width, frame height and coefficients are written over APB
// while the block is idle.
// Words are handled one at a time through a single shared multiply-accumulate
// that steps over the 2K-1 tap terms of each pass. A border column takes no
// pass, an interior column of a border row takes the horizontal pass, and an
// interior pixel with a result takes the horizontal and the vertical pass.
// A result is on o_res once its vertical pass is done; the next pixel is taken
// while it waits. If the receiver stalls, the following result is held in the
// sequencer and no further pixel is taken until the output word is free.
// Reset clears counters, pixel window and the output valid; the line store
// is not cleared and needs 2K-2 rows of a frame before it is read.
// ----------------------------------------------------------------------------
module separable_symmetric_gaussian_smooth #(
    parameter int MAX_TAPS   = ssgs_pkg::DEF_MAX_TAPS,
    parameter int MAX_WIDTH  = ssgs_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = ssgs_pkg::DEF_PIXEL_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ssgs_px_if.sink                     i_px,
    ssgs_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssgs_pkg::APB_AW-1:0] paddr,
    input  logic [ssgs_pkg::APB_DW-1:0] pwdata,
    output logic [ssgs_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import ssgs_pkg::*;

    localparam int JW = $clog2(2 * MAX_TAPS - 1);

    t_cfg          cfg;
    t_cmd          cmd;
    t_stat         stat;
    logic [JW-1:0] idx, last_idx;

    ssgs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ssgs_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_px.valid),
        .o_in_ready (i_px.ready),
        .i_stat     (stat),
        .i_last_idx (last_idx),
        .o_cmd      (cmd),
        .o_idx      (idx)
    );

    ssgs_dp #(
        .MAX_TAPS   (MAX_TAPS),
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .i_idx           (idx),
        .o_stat          (stat),
        .o_last_idx      (last_idx),
        .i_pixel         (i_px.pixel),
        .i_frame_start   (i_px.frame_start),
        .o_valid         (o_res.valid),
        .i_ready         (o_res.ready),
        .o_smoothed      (o_res.smoothed),
        .o_out_row       (o_res.out_row),
        .o_out_col       (o_res.out_col),
        .o_last_of_frame (o_res.last_of_frame)
    );

endmodule

// ===== tb/ssgs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssgs_checker
// Watches the pixel, result and APB channels of the smoothing block, keeps
// its own copy of the filter state, predicts each result word and compares it
// field by field with what the block delivers.
// ----------------------------------------------------------------------------
module ssgs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssgs_px_if          i_px,
    ssgs_res_if         i_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ssgs_pkg::APB_AW-1:0] paddr,
    input  logic [ssgs_pkg::APB_DW-1:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_seen
);
    import ssgs_pkg::*;

    typedef struct {
        logic [15:0] smoothed;
        logic [11:0] row;
        logic [9:0]  col;
        logic        last;
    } t_blur_word;

    t_blur_word  blur_q[$];

    logic [3:0]  taps_r;
    logic [10:0] width_r;
    logic [12:0] height_r;
    logic [63:0] coef_lo_r;
    logic [63:0] coef_hi_r;

    logic [15:0] win[15];
    logic [19:0] lines[14][1024];
    int unsigned row_pos;
    int unsigned col_pos;

    function automatic longint unsigned coef_of(int unsigned i);
        if (i < 4) return longint'(coef_lo_r[16*i +: 16]);
        if (i < 8) return longint'(coef_hi_r[16*(i-4) +: 16]);
        return 0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic predict_pixel(input logic [15:0] pix, input logic fs);
        int unsigned k, w, hr, r, c, cc, centre, i;
        longint unsigned acc, hv, v, up, dn, rnd;
        t_blur_word e;
        k  = (taps_r == 0) ? 1 : ((taps_r > 8) ? 8 : taps_r);
        w  = (width_r == 0) ? 1 : ((width_r > 1024) ? 1024 : width_r);
        hr = (height_r == 0) ? 1 : ((height_r > 4096) ? 4096 : height_r);
        if (fs) begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        for (i = 14; i > 0; i--) win[i] = win[i-1];
        win[0] = pix;
        if (c < w && c >= 2*k - 2) begin
            cc  = c - (k - 1);
            acc = longint'(win[k-1]) * coef_of(0);
            for (i = 1; i < k; i++)
                acc += (longint'(win[k-1-i]) + longint'(win[k-1+i])) * coef_of(i);
            hv = (acc + (64'd1 << 10)) >> 11;
            if (hv > 64'hF_FFFF) hv = 64'hF_FFFF;
            if (r < hr && r >= 2*k - 2) begin
                centre = r - (k - 1);
                if (k == 1) v = hv * coef_of(0);
                else v = longint'(lines[centre % 14][cc]) * coef_of(0);
                for (i = 1; i < k; i++) begin
                    up = longint'(lines[(centre - i) % 14][cc]);
                    dn = (centre + i == r) ? hv : longint'(lines[(centre + i) % 14][cc]);
                    v += (up + dn) * coef_of(i);
                end
                rnd = (v + (64'd1 << 18)) >> 19;
                if (rnd > 64'hFFFF) rnd = 64'hFFFF;
                e.smoothed = rnd[15:0];
                e.row      = centre[11:0];
                e.col      = cc[9:0];
                e.last     = (r == hr - 1 && c == w - 1);
                blur_q.push_back(e);
            end
            lines[r % 14][cc] = hv[19:0];
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= hr) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_words_seen = 0;
    end

    always @(posedge i_clk) begin
        t_blur_word e;
        if (!i_rst_n) begin
            taps_r    = 4'd1;
            width_r   = 11'd640;
            height_r  = 13'd480;
            coef_lo_r = 64'd32768;
            coef_hi_r = 64'd0;
            for (int i = 0; i < 15; i++) win[i] = '0;
            row_pos = 0;
            col_pos = 0;
            blur_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                o_words_seen++;
                if (blur_q.size() == 0) begin
                    report_mismatch("unexpected word, row", i_res.out_row, -1);
                end else begin
                    e = blur_q.pop_front();
                    if (i_res.smoothed !== e.smoothed)
                        report_mismatch("smoothed", i_res.smoothed, e.smoothed);
                    if (i_res.out_row !== e.row)
                        report_mismatch("out_row", i_res.out_row, e.row);
                    if (i_res.out_col !== e.col)
                        report_mismatch("out_col", i_res.out_col, e.col);
                    if (i_res.last_of_frame !== e.last)
                        report_mismatch("last_of_frame", i_res.last_of_frame, e.last);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_TAPS:    taps_r    = pwdata[3:0];
                    REG_WIDTH:   width_r   = pwdata[10:0];
                    REG_HEIGHT:  height_r  = pwdata[12:0];
                    REG_COEF_LO: coef_lo_r = pwdata;
                    REG_COEF_HI: coef_hi_r = pwdata;
                    default: ;
                endcase
            end
            if (i_px.valid && i_px.ready)
                predict_pixel(i_px.pixel, i_px.frame_start);
        end
        o_pending = blur_q.size();
    end
endmodule

// ===== tb/separable_symmetric_gaussian_smooth_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// separable_symmetric_gaussian_smooth_tb
// Drives frames of random pixels through the smoothing block under a series
// of tap, size and coefficient settings, with random gaps on both channels
// and one long output stall. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module separable_symmetric_gaussian_smooth_tb;
    import ssgs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          words_seen;
    int          sent;
    bit          calm;
    int          hold;
    bit          held_once;

    ssgs_px_if  px_if ();
    ssgs_res_if res_if ();

    separable_symmetric_gaussian_smooth dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_px    (px_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ssgs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_px         (px_if),
        .i_res        (res_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_words_seen (words_seen)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // result sink: random gaps, one long hold-off once traffic is flowing
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold         <= 0;
            held_once    <= 1'b0;
        end else if (hold > 0) begin
            hold         <= hold - 1;
            res_if.ready <= 1'b0;
        end else if (!held_once && words_seen >= 150) begin
            held_once    <= 1'b1;
            hold         <= 400;
            res_if.ready <= 1'b0;
        end else if (calm) begin
            res_if.ready <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                res_if.ready <= 1'b1;
            end else if (r < 97) begin
                res_if.ready <= 1'b0;
                hold         <= $urandom_range(0, 3);
            end else begin
                res_if.ready <= 1'b0;
                hold         <= $urandom_range(10, 40);
            end
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [3:0] k, input logic [10:0] w, input logic [12:0] h,
                             input logic [63:0] lo, input logic [63:0] hi);
        apb_write(REG_TAPS, {60'd0, k});
        apb_write(REG_WIDTH, {53'd0, w});
        apb_write(REG_HEIGHT, {51'd0, h});
        apb_write(REG_COEF_LO, lo);
        apb_write(REG_COEF_HI, hi);
    endtask

    task automatic push_pixel(input logic [15:0] p, input logic fs);
        int gap, r;
        gap = 0;
        if (!calm) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(5, 30);
            else if (r >= 70) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            px_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        px_if.valid       <= 1'b1;
        px_if.pixel       <= p;
        px_if.frame_start <= fs;
        @(posedge i_clk);
        while (!px_if.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic settle();
        px_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 16'h0000;
        if (r < 10) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic rand_coeffs(input int k, output logic [63:0] lo, output logic [63:0] hi);
        logic [15:0] c[8];
        int mode, lim;
        mode = $urandom_range(0, 9);
        lim  = 32768 / (2 * k);
        for (int i = 0; i < 8; i++) begin
            if (mode < 6) c[i] = (i == 0) ? 16'($urandom_range(0, 32768))
                                          : 16'($urandom_range(0, lim));
            else if (mode < 8) c[i] = 16'($urandom_range(0, 65535));
            else if (mode == 8) c[i] = 16'hFFFF;
            else c[i] = 16'h0000;
        end
        lo = {c[3], c[2], c[1], c[0]};
        hi = {c[7], c[6], c[5], c[4]};
    endtask

    task automatic run_frames(input int w, input int h, input int n);
        int flen;
        flen = w * h;
        for (int i = 0; i < n; i++)
            push_pixel(rand_pixel(), (i % flen == 0) || ($urandom_range(0, 99) < 1));
    endtask

    initial begin
        logic [3:0]  k;
        logic [10:0] w;
        logic [12:0] h;
        logic [63:0] lo, hi;
        int ke, we, he, n, r;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        px_if.valid       = 1'b0;
        px_if.pixel       = '0;
        px_if.frame_start = 1'b0;
        sent              = 0;
        calm              = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate sizes and taps, all read as one
        configure(4'd0, 11'd0, 13'd0, 64'd32768, 64'd0);
        push_pixel(16'h0000, 1'b1);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'h8001, 1'b0);
        settle();
        // saturating coefficients
        configure(4'd2, 11'd3, 13'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int i = 0; i < 9; i++) push_pixel(16'hFFFF, i == 0);
        settle();
        // oversized taps, width and height saturate
        configure(4'd15, 11'd2047, 13'd8191, 64'h1000_1000_1000_1000, 64'h1000_1000_1000_1000);
        for (int i = 0; i < 10; i++) push_pixel(rand_pixel(), i == 0);
        settle();

        while (sent < 2000) begin
            r = $urandom_range(0, 99);
            if (r < 90) k = 4'($urandom_range(1, 8));
            else if (r < 93) k = 4'd0;
            else k = 4'($urandom_range(9, 15));
            r = $urandom_range(0, 99);
            if (r < 85) w = 11'($urandom_range(1, 24));
            else begin
                case ($urandom_range(0, 3))
                    0: w = 11'd0;
                    1: w = 11'd1024;
                    2: w = 11'd2047;
                    default: w = 11'($urandom_range(25, 1023));
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 85) h = 13'($urandom_range(1, 16));
            else begin
                case ($urandom_range(0, 2))
                    0: h = 13'd0;
                    1: h = 13'd4096;
                    default: h = 13'd8191;
                endcase
            end
            ke = (k == 0) ? 1 : ((k > 8) ? 8 : k);
            we = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
            he = (h == 0) ? 1 : ((h > 4096) ? 4096 : h);
            rand_coeffs(ke, lo, hi);
            configure(k, w, h, lo, hi);
            calm = ($urandom_range(0, 4) == 0);
            n = we * he * $urandom_range(1, 3);
            if (n > 400) n = 400;
            run_frames(we, he, n);
            settle();
            calm = 1'b0;
        end

        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/ssgs_pkg.sv
design/ssgs_px_if.sv
design/ssgs_res_if.sv
design/ssgs_regs.sv
design/ssgs_ctrl.sv
design/ssgs_dp.sv
design/separable_symmetric_gaussian_smooth.sv
tb/ssgs_checker.sv
tb/separable_symmetric_gaussian_smooth_tb.sv
